/* rtl/core/bsm_pkg.sv */
// Shared widths and pipeline record types for the bounding sphere merge core.
package bsm_pkg;

	localparam int CW    = 32;          // coordinate width
	localparam int RW    = 31;          // radius width
	localparam int MW    = 32;          // offset magnitude width
	localparam int DW    = 66;          // squared distance width
	localparam int SQW   = 33;          // square root width
	localparam int REMW  = 35;          // square root remainder width
	localparam int KW    = 33;          // radius step width
	localparam int NW    = 66;          // offset product width
	localparam int QW    = 33;          // division word width
	localparam int NSQ   = 33;          // square root steps
	localparam int NDIV  = 33;          // division steps

	// Record that rides along the square root chain.
	typedef struct packed {
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] b;
		logic [2:0][MW-1:0] mag;
		logic [2:0]         neg;
		logic [RW-1:0]      ra;
		logic [RW-1:0]      rb;
		logic [2*RW-1:0]    ra2;
		logic               enclose;
		logic               overlap;
	} side_t;

	// Record that rides along the division chain.
	typedef struct packed {
		logic [2:0][CW-1:0] base;
		logic [2:0]         neg;
		logic               use_off;
		logic [RW-1:0]      radius;
		logic [2*RW-1:0]    rsq;
		logic [2*RW-1:0]    ra2;
		logic               overlap;
		logic [SQW-1:0]     d;
	} tail_t;

endpackage

/* rtl/core/bounding_sphere_merge_core.sv */
// Top level: smallest enclosing sphere of two spheres, fully pipelined.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | a_center_*, a_radius, b_center_*, b_radius
//  out     | out_valid / out_stall| merged_*, merged_radius, spheres_overlap,
//          |                      | growth
//
// One request enters per cycle unless in_stall is high; each passes through three
// front stages, 33 square root cells, two stages of radius and product work, 33
// divider cells and the output register. All stages share one enable, so a
// stall at the output holds the whole chain while a result waits there;
// bubbles inside the chain are not squeezed out. Reset clears the valid bits only.
module bounding_sphere_merge_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] a_center_x,
	input  logic [31:0] a_center_y,
	input  logic [31:0] a_center_z,
	input  logic [30:0] a_radius,
	input  logic [31:0] b_center_x,
	input  logic [31:0] b_center_y,
	input  logic [31:0] b_center_z,
	input  logic [30:0] b_radius,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] merged_x,
	output logic [31:0] merged_y,
	output logic [31:0] merged_z,
	output logic [30:0] merged_radius,
	output logic        spheres_overlap,
	output logic [63:0] growth
);
	import bsm_pkg::*;

	logic en;

	logic                 f_vld;
	side_t                f_side;
	logic [DW-1:0]        f_dist;

	logic [NSQ:0]               sq_vld;
	side_t [NSQ:0]              sq_side;
	logic [NSQ:0][DW-1:0]       sq_dist;
	logic [NSQ:0][SQW-1:0]      sq_root;
	logic [NSQ:0][REMW-1:0]     sq_rem;

	logic                 vld_m1, vld_m2;
	tail_t                tail_m1, tail_m2;
	logic [2:0][MW-1:0]   mag_m1;
	logic [KW-1:0]        k_m1;
	logic [2:0][NW-1:0]   prod_m2;

	logic [SQW:0]         fsum;
	logic [SQW-1:0]       full;
	logic                 a_big;
	side_t                s_last;

	logic [NDIV:0]                dv_vld;
	tail_t [NDIV:0]               dv_tail;
	logic [NDIV:0][2:0][QW-1:0]   dv_rem;
	logic [NDIV:0][2:0][QW-1:0]   dv_quo;

	tail_t                t_last;
	logic [2:0][CW+2:0]   csum;
	logic [2:0][CW-1:0]   cres;

	logic                 vld_q;
	logic [2:0][CW-1:0]   cen_q;
	logic [RW-1:0]        rad_q;
	logic                 ovl_q;
	logic [63:0]          grow_q;

	// Advance the whole chain unless a result is held at the output
	assign en       = !vld_q || !out_stall;
	assign in_stall = !en;

	bsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (in_valid),
		.a_in     ({a_center_z, a_center_y, a_center_x}),
		.b_in     ({b_center_z, b_center_y, b_center_x}),
		.ra_in    (a_radius),
		.rb_in    (b_radius),
		.vld_out  (f_vld),
		.side_out (f_side),
		.dist_out (f_dist)
	);

	// Square root chain, most significant bit pair first
	assign sq_vld[0]  = f_vld;
	assign sq_side[0] = f_side;
	assign sq_dist[0] = f_dist;
	assign sq_root[0] = '0;
	assign sq_rem[0]  = '0;

	for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
		bsm_sqrt_cell #(.STEP(NSQ - 1 - g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (sq_vld[g]),
			.side_in  (sq_side[g]),
			.dist_in  (sq_dist[g]),
			.root_in  (sq_root[g]),
			.rem_in   (sq_rem[g]),
			.vld_out  (sq_vld[g+1]),
			.side_out (sq_side[g+1]),
			.dist_out (sq_dist[g+1]),
			.root_out (sq_root[g+1]),
			.rem_out  (sq_rem[g+1])
		);
	end

	// Merged radius and the step from A toward B
	assign s_last = sq_side[NSQ];
	assign fsum   = {1'b0, sq_root[NSQ]} + (SQW+1)'(s_last.ra) + (SQW+1)'(s_last.rb);
	assign full   = fsum[SQW:1];
	assign a_big  = s_last.ra > s_last.rb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
		end else if (en) begin
			vld_m1 <= sq_vld[NSQ];
			vld_m2 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_m1.neg     <= s_last.neg;
			tail_m1.ra2     <= s_last.ra2;
			tail_m1.overlap <= s_last.overlap;
			tail_m1.d       <= sq_root[NSQ];
			tail_m1.rsq     <= '0;
			tail_m1.use_off <= !s_last.enclose && (sq_root[NSQ] != '0);
			tail_m1.base    <= (s_last.enclose && !a_big) ? s_last.b : s_last.a;
			if (s_last.enclose) begin
				tail_m1.radius <= a_big ? s_last.ra : s_last.rb;
			end else begin
				tail_m1.radius <= (full > SQW'({RW{1'b1}})) ? {RW{1'b1}} : RW'(full);
			end
			k_m1   <= (full > SQW'(s_last.ra)) ? KW'(full - SQW'(s_last.ra)) : '0;
			mag_m1 <= s_last.mag;

			tail_m2.base    <= tail_m1.base;
			tail_m2.neg     <= tail_m1.neg;
			tail_m2.use_off <= tail_m1.use_off;
			tail_m2.radius  <= tail_m1.radius;
			tail_m2.ra2     <= tail_m1.ra2;
			tail_m2.overlap <= tail_m1.overlap;
			tail_m2.d       <= tail_m1.d;
			tail_m2.rsq     <= (2*RW)'(tail_m1.radius) * (2*RW)'(tail_m1.radius);
			for (int i = 0; i < 3; i++) begin
				prod_m2[i] <= NW'(mag_m1[i]) * NW'(k_m1);
			end
		end
	end

	// Divider chain: offset product over distance
	assign dv_vld[0]  = vld_m2;
	assign dv_tail[0] = tail_m2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_rem[0][i] = prod_m2[i][NW-1:QW];
			dv_quo[0][i] = prod_m2[i][QW-1:0];
		end
	end

	for (genvar g = 0; g < NDIV; g++) begin : g_div
		bsm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (dv_vld[g]),
			.tail_in  (dv_tail[g]),
			.rem_in   (dv_rem[g]),
			.quo_in   (dv_quo[g]),
			.vld_out  (dv_vld[g+1]),
			.tail_out (dv_tail[g+1]),
			.rem_out  (dv_rem[g+1]),
			.quo_out  (dv_quo[g+1])
		);
	end

	// Move the center and saturate
	assign t_last = dv_tail[NDIV];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			csum[i] = {{3{t_last.base[i][CW-1]}}, t_last.base[i]};
			if (t_last.use_off) begin
				if (t_last.neg[i]) begin
					csum[i] = csum[i] - (CW+3)'(dv_quo[NDIV][i]);
				end else begin
					csum[i] = csum[i] + (CW+3)'(dv_quo[NDIV][i]);
				end
			end
			if (!csum[i][CW+2] && (csum[i][CW+1:CW-1] != '0)) begin
				cres[i] = {1'b0, {(CW-1){1'b1}}};
			end else if (csum[i][CW+2] && (csum[i][CW+1:CW-1] != '1)) begin
				cres[i] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				cres[i] = csum[i][CW-1:0];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cen_q  <= cres;
			rad_q  <= t_last.radius;
			ovl_q  <= t_last.overlap;
			grow_q <= 64'(t_last.rsq) - 64'(t_last.ra2);
		end
	end

	assign out_valid       = vld_q;
	assign merged_x        = cen_q[0];
	assign merged_y        = cen_q[1];
	assign merged_z        = cen_q[2];
	assign merged_radius   = rad_q;
	assign spheres_overlap = ovl_q;
	assign growth          = grow_q;

endmodule

/* rtl/core/bsm_front.sv */
// Front stages: center offsets, squares and distance tests.
module bsm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [2:0][bsm_pkg::CW-1:0]   a_in,
	input  logic [2:0][bsm_pkg::CW-1:0]   b_in,
	input  logic [bsm_pkg::RW-1:0]        ra_in,
	input  logic [bsm_pkg::RW-1:0]        rb_in,
	output logic                          vld_out,
	output bsm_pkg::side_t                side_out,
	output logic [bsm_pkg::DW-1:0]        dist_out
);
	import bsm_pkg::*;

	logic                 vld_s1, vld_s2;
	side_t                side_s1, side_s2, side_s3;
	logic [RW-1:0]        rd_s1;
	logic [RW:0]          rsum_s1;
	logic [2:0][2*MW-1:0] sq_s2;
	logic [2*RW-1:0]      rd2_s2;
	logic [2*RW+1:0]      rsum2_s2;
	logic [DW-1:0]        dist_s3;
	logic                 vld_s3;
	logic [2:0][CW:0]     diff;
	logic [DW-1:0]        dsum;

	// Offsets of B from A on each axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {b_in[i][CW-1], b_in[i]} - {a_in[i][CW-1], a_in[i]};
		end
	end

	assign dsum = DW'(sq_s2[0]) + DW'(sq_s2[1]) + DW'(sq_s2[2]);

	// Hold valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Advance payload: magnitudes, then squares, then distance compare
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.a       <= a_in;
			side_s1.b       <= b_in;
			side_s1.ra      <= ra_in;
			side_s1.rb      <= rb_in;
			side_s1.ra2     <= '0;
			side_s1.enclose <= 1'b0;
			side_s1.overlap <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				side_s1.neg[i] <= diff[i][CW];
				side_s1.mag[i] <= diff[i][CW] ? MW'(-diff[i]) : MW'(diff[i]);
			end
			rd_s1   <= (ra_in > rb_in) ? ra_in - rb_in : rb_in - ra_in;
			rsum_s1 <= {1'b0, ra_in} + {1'b0, rb_in};

			side_s2.a       <= side_s1.a;
			side_s2.b       <= side_s1.b;
			side_s2.mag     <= side_s1.mag;
			side_s2.neg     <= side_s1.neg;
			side_s2.ra      <= side_s1.ra;
			side_s2.rb      <= side_s1.rb;
			side_s2.enclose <= side_s1.enclose;
			side_s2.overlap <= side_s1.overlap;
			side_s2.ra2     <= (2*RW)'(side_s1.ra) * (2*RW)'(side_s1.ra);
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= (2*MW)'(side_s1.mag[i]) * (2*MW)'(side_s1.mag[i]);
			end
			rd2_s2   <= (2*RW)'(rd_s1) * (2*RW)'(rd_s1);
			rsum2_s2 <= (2*RW+2)'(rsum_s1) * (2*RW+2)'(rsum_s1);

			side_s3.a       <= side_s2.a;
			side_s3.b       <= side_s2.b;
			side_s3.mag     <= side_s2.mag;
			side_s3.neg     <= side_s2.neg;
			side_s3.ra      <= side_s2.ra;
			side_s3.rb      <= side_s2.rb;
			side_s3.ra2     <= side_s2.ra2;
			side_s3.enclose <= dsum <= DW'(rd2_s2);
			side_s3.overlap <= dsum < DW'(rsum2_s2);
			dist_s3         <= dsum;
		end
	end

	assign vld_out  = vld_s3;
	assign side_out = side_s3;
	assign dist_out = dist_s3;

endmodule

/* rtl/core/bsm_sqrt_cell.sv */
// One digit step of the restoring square root chain.
module bsm_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_in,
	input  bsm_pkg::side_t              side_in,
	input  logic [bsm_pkg::DW-1:0]      dist_in,
	input  logic [bsm_pkg::SQW-1:0]     root_in,
	input  logic [bsm_pkg::REMW-1:0]    rem_in,
	output logic                        vld_out,
	output bsm_pkg::side_t              side_out,
	output logic [bsm_pkg::DW-1:0]      dist_out,
	output logic [bsm_pkg::SQW-1:0]     root_out,
	output logic [bsm_pkg::REMW-1:0]    rem_out
);
	import bsm_pkg::*;

	logic                 vld_q;
	side_t                side_q;
	logic [DW-1:0]        dist_q;
	logic [SQW-1:0]       root_q;
	logic [REMW-1:0]      rem_q;
	logic [REMW+1:0]      remx, trial;
	logic                 take;

	// Bring down the next bit pair and try the next root bit
	assign remx  = {rem_in, dist_in[2*STEP+1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign take  = remx >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			dist_q <= dist_in;
			root_q <= {root_in[SQW-2:0], take};
			rem_q  <= take ? REMW'(remx - trial) : REMW'(remx);
		end
	end

	assign vld_out  = vld_q;
	assign side_out = side_q;
	assign dist_out = dist_q;
	assign root_out = root_q;
	assign rem_out  = rem_q;

endmodule

/* rtl/core/bsm_div_cell.sv */
// One quotient bit of the restoring divider, three axes side by side.
module bsm_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  bsm_pkg::tail_t                tail_in,
	input  logic [2:0][bsm_pkg::QW-1:0]   rem_in,
	input  logic [2:0][bsm_pkg::QW-1:0]   quo_in,
	output logic                          vld_out,
	output bsm_pkg::tail_t                tail_out,
	output logic [2:0][bsm_pkg::QW-1:0]   rem_out,
	output logic [2:0][bsm_pkg::QW-1:0]   quo_out
);
	import bsm_pkg::*;

	logic               vld_q;
	tail_t              tail_q;
	logic [2:0][QW-1:0] rem_q, quo_q;
	logic [2:0][QW:0]   t;
	logic [2:0]         ge;

	// Shift in the next dividend bit and subtract the distance where it fits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i]  = {rem_in[i], quo_in[i][QW-1]};
			ge[i] = t[i] >= {1'b0, tail_in.d};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_q <= tail_in;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? QW'(t[i] - {1'b0, tail_in.d}) : QW'(t[i]);
				quo_q[i] <= {quo_in[i][QW-2:0], ge[i]};
			end
		end
	end

	assign vld_out  = vld_q;
	assign tail_out = tail_q;
	assign rem_out  = rem_q;
	assign quo_out  = quo_q;

endmodule
